// ----- rtl/tqf_pkg.sv -----
// Shared types, sizes and codes of the three-queue FIFO cache.
package tqf_pkg;

    localparam int CAPACITY       = 64;
    localparam int GHOST_DEPTH    = 64;
    localparam int KEY_BITS       = 32;
    localparam int DATA_BITS      = 32;
    localparam int COUNT_BITS     = 4;
    localparam int SLOT_IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS       = $clog2(CAPACITY + 1);
    localparam int GHOST_IDX_BITS = (GHOST_DEPTH > 1) ? $clog2(GHOST_DEPTH) : 1;
    localparam int GCNT_BITS      = $clog2(GHOST_DEPTH + 1);
    localparam int CFG_BITS       = 7;
    localparam int OCC_BITS       = 7;

    typedef enum logic [1:0] {
        OP_GET      = 2'd0,
        OP_PUT      = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_CONTAINS = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_SMALL_LIMIT = 2'd0,
        CFG_GHOST_LIMIT = 2'd1,
        CFG_THRESHOLD   = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        op_t                  opcode;
        logic signed [31:0]   key;
        logic signed [31:0]   write_value;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic signed [31:0]   read_value;
        logic [OCC_BITS-1:0]  occupancy;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [DATA_BITS-1:0]  data;
        logic [COUNT_BITS-1:0] hits;
    } slot_entry_t;

    typedef struct packed {
        logic                     shift_en;
        logic [SLOT_IDX_BITS-1:0] shift_pos;
        logic                     push_en;
        logic [SLOT_IDX_BITS-1:0] push_pos;
        slot_entry_t              push_ent;
        logic                     upd_en;
        logic                     upd_data_en;
        logic [SLOT_IDX_BITS-1:0] upd_pos;
        logic [DATA_BITS-1:0]     upd_data;
        logic [COUNT_BITS-1:0]    upd_hits;
    } slot_cmd_t;

    typedef struct packed {
        logic                      shift_en;
        logic [GHOST_IDX_BITS-1:0] shift_pos;
        logic                      push_en;
        logic [GHOST_IDX_BITS-1:0] push_pos;
        logic [KEY_BITS-1:0]       push_key;
    } ghost_cmd_t;

endpackage

// ----- rtl/tqf_slot_cell.sv -----
// One resident entry of a queue chain; cell 0 holds the oldest entry.
module tqf_slot_cell (
    input  logic                              clk,
    input  logic [tqf_pkg::SLOT_IDX_BITS-1:0] idx,
    input  tqf_pkg::slot_cmd_t                cmd,
    input  tqf_pkg::slot_entry_t              nxt,
    output tqf_pkg::slot_entry_t              ent
);

    tqf_pkg::slot_entry_t ent_reg;
    tqf_pkg::slot_entry_t ent_next;

    always_comb
    begin
        ent_next = ent_reg;
        if (cmd.shift_en && (idx >= cmd.shift_pos))
        begin
            // close the gap: take the younger neighbor
            ent_next = nxt;
        end
        else if (cmd.push_en && (idx == cmd.push_pos))
        begin
            ent_next = cmd.push_ent;
        end
        else if (cmd.upd_en && (idx == cmd.upd_pos))
        begin
            ent_next.hits = cmd.upd_hits;
            if (cmd.upd_data_en)
            begin
                ent_next.data = cmd.upd_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

// ----- rtl/tqf_ghost_cell.sv -----
// One remembered key of the ghost chain; cell 0 holds the oldest key.
module tqf_ghost_cell (
    input  logic                               clk,
    input  logic [tqf_pkg::GHOST_IDX_BITS-1:0] idx,
    input  tqf_pkg::ghost_cmd_t                cmd,
    input  logic [tqf_pkg::KEY_BITS-1:0]       nxt,
    output logic [tqf_pkg::KEY_BITS-1:0]       key
);

    logic [tqf_pkg::KEY_BITS-1:0] key_reg;
    logic [tqf_pkg::KEY_BITS-1:0] key_next;

    always_comb
    begin
        key_next = key_reg;
        if (cmd.shift_en && (idx >= cmd.shift_pos))
        begin
            key_next = nxt;
        end
        else if (cmd.push_en && (idx == cmd.push_pos))
        begin
            key_next = cmd.push_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

// ----- rtl/three_queue_fifo_cache.sv -----
// Top level of the three-queue FIFO cache: controller and the three cell chains.
//
// Requests enter on req (req_valid / req_stall), one item at a time; each gives
// exactly one result item on rsp (rsp_valid / rsp_stall). Configuration is
// written through cfg_we / cfg_index / cfg_data; the user must write it only
// while no request is in flight, and the block itself does not enforce this.
// Entries live in two chains of cells (small and main queue), keys of evicted
// entries in a ghost chain; cell 0 of each chain holds its oldest entry.
// A request without eviction passes capture, lookup, update and result. A put
// miss adds an eviction check and an insert, and a main room check when its key
// is a ghost. Each small-queue eviction adds another eviction check plus a push
// into main or the ghost list; a get that promotes adds the push. Every
// main-queue eviction repeats the main room check, every ghost trim the ghost push.
// The next request is taken once the current one has loaded the output
// register; a result waiting under rsp_stall holds the block only when the
// following result is ready to load. Reset empties all queues and loads
// small_limit 6, ghost_limit 58 and promote_threshold 2.
module three_queue_fifo_cache (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  tqf_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output tqf_pkg::rsp_t                rsp,
    input  logic                         cfg_we,
    input  tqf_pkg::cfg_index_t          cfg_index,
    input  logic [tqf_pkg::CFG_BITS-1:0] cfg_data
);

    localparam int CAP  = tqf_pkg::CAPACITY;
    localparam int GD   = tqf_pkg::GHOST_DEPTH;
    localparam int SIB  = tqf_pkg::SLOT_IDX_BITS;
    localparam int CB   = tqf_pkg::CNT_BITS;
    localparam int GIB  = tqf_pkg::GHOST_IDX_BITS;
    localparam int GCB  = tqf_pkg::GCNT_BITS;
    localparam int HB   = tqf_pkg::COUNT_BITS;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LOOK   = 8'b0000_0010,
        ST_ACT    = 8'b0000_0100,
        ST_SEV    = 8'b0000_1000,
        ST_GADD   = 8'b0001_0000,
        ST_MROOM  = 8'b0010_0000,
        ST_INSERT = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0] small_limit_reg;
    logic [6:0] ghost_limit_reg;
    logic [3:0] threshold_reg;

    tqf_pkg::req_t req_reg;
    logic [CB-1:0]  s_cnt_reg, m_cnt_reg;
    logic [GCB-1:0] g_cnt_reg;

    logic s_hit_reg, m_hit_reg, g_hit_reg;
    logic [SIB-1:0] pos_reg;
    logic [GIB-1:0] g_pos_reg;
    logic [tqf_pkg::DATA_BITS-1:0] hit_data_reg;
    logic [HB-1:0] hit_cnt_reg;

    tqf_pkg::slot_entry_t mv_reg, mv_next;
    logic from_sev_reg, from_sev_next;
    logic room_move_reg, room_move_next;
    logic ghost_mode_reg, ghost_mode_next;
    logic [tqf_pkg::KEY_BITS-1:0] gkey_reg, gkey_next;

    tqf_pkg::rsp_t rsp_reg;
    logic rsp_valid_reg;
    logic fin_load;

    tqf_pkg::slot_cmd_t  s_cmd, m_cmd;
    tqf_pkg::ghost_cmd_t g_cmd;
    tqf_pkg::slot_entry_t small_ent [CAP];
    tqf_pkg::slot_entry_t main_ent [CAP];
    logic [tqf_pkg::KEY_BITS-1:0] ghost_key [GD];

    // cell chains
    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++)
        begin : g_slot
            tqf_pkg::slot_entry_t s_nxt, m_nxt;
            if (gi == CAP - 1)
            begin : g_end
                assign s_nxt = '0;
                assign m_nxt = '0;
            end
            else
            begin : g_mid
                assign s_nxt = small_ent[gi+1];
                assign m_nxt = main_ent[gi+1];
            end
            tqf_slot_cell u_small (
                .clk (clk), .idx (SIB'(gi)), .cmd (s_cmd), .nxt (s_nxt),
                .ent (small_ent[gi])
            );
            tqf_slot_cell u_main (
                .clk (clk), .idx (SIB'(gi)), .cmd (m_cmd), .nxt (m_nxt),
                .ent (main_ent[gi])
            );
        end
        for (gi = 0; gi < GD; gi++)
        begin : g_ghost
            logic [tqf_pkg::KEY_BITS-1:0] g_nxt;
            if (gi == GD - 1)
            begin : g_end
                assign g_nxt = '0;
            end
            else
            begin : g_mid
                assign g_nxt = ghost_key[gi+1];
            end
            tqf_ghost_cell u_ghost (
                .clk (clk), .idx (GIB'(gi)), .cmd (g_cmd), .nxt (g_nxt),
                .key (ghost_key[gi])
            );
        end
    endgenerate

    // associative match; keys are unique per chain, so matches are one-hot
    logic s_hit, m_hit, g_hit;
    logic [SIB-1:0] s_pos, m_pos;
    logic [GIB-1:0] g_pos;
    logic [tqf_pkg::DATA_BITS-1:0] s_data, m_data;
    logic [HB-1:0] s_hits, m_hits;

    always_comb
    begin
        s_hit = 1'b0; m_hit = 1'b0; g_hit = 1'b0;
        s_pos = '0; m_pos = '0; g_pos = '0;
        s_data = '0; m_data = '0; s_hits = '0; m_hits = '0;
        for (int i = 0; i < CAP; i++)
        begin
            if ((CB'(i) < s_cnt_reg) && (small_ent[i].key == req_reg.key))
            begin
                s_hit  = 1'b1;
                s_pos  = s_pos | SIB'(i);
                s_data = s_data | small_ent[i].data;
                s_hits = s_hits | small_ent[i].hits;
            end
            if ((CB'(i) < m_cnt_reg) && (main_ent[i].key == req_reg.key))
            begin
                m_hit  = 1'b1;
                m_pos  = m_pos | SIB'(i);
                m_data = m_data | main_ent[i].data;
                m_hits = m_hits | main_ent[i].hits;
            end
        end
        for (int j = 0; j < GD; j++)
        begin
            if ((GCB'(j) < g_cnt_reg) && (ghost_key[j] == req_reg.key))
            begin
                g_hit = 1'b1;
                g_pos = g_pos | GIB'(j);
            end
        end
    end

    // effective limits
    logic [10:0] sl_wide, gl_wide;
    logic [CB-1:0] eff_small, main_bound;
    logic [GCB-1:0] ghost_lim;

    always_comb
    begin
        sl_wide = 11'(small_limit_reg);
        if (sl_wide == 11'd0)
        begin
            sl_wide = 11'd1;
        end
        else if (sl_wide >= 11'(CAP))
        begin
            sl_wide = 11'(CAP - 1);
        end
        eff_small  = CB'(sl_wide);
        main_bound = CB'(CAP) - eff_small;
        gl_wide    = 11'(ghost_limit_reg);
        if (gl_wide > 11'(GD))
        begin
            gl_wide = 11'(GD);
        end
        ghost_lim = GCB'(gl_wide);
    end

    logic [HB-1:0] hits_inc;
    logic [CB:0]   total;
    logic          sev_go;

    assign hits_inc = (hit_cnt_reg == {HB{1'b1}}) ? hit_cnt_reg : hit_cnt_reg + 1'b1;
    assign total    = {1'b0, s_cnt_reg} + {1'b0, m_cnt_reg};
    assign sev_go   = ghost_mode_reg ? (s_cnt_reg > eff_small) : (s_cnt_reg >= eff_small);

    always_comb
    begin
        state_next      = state_reg;
        s_cmd           = '0;
        m_cmd           = '0;
        g_cmd           = '0;
        mv_next         = mv_reg;
        from_sev_next   = from_sev_reg;
        room_move_next  = room_move_reg;
        ghost_mode_next = ghost_mode_reg;
        gkey_next       = gkey_reg;
        fin_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                ghost_mode_next = 1'b0;
                state_next      = ST_ACT;
            end
            ST_ACT:
            begin
                state_next = ST_FIN;
                case (req_reg.opcode)
                    tqf_pkg::OP_GET:
                    begin
                        if (s_hit_reg && (8'(hits_inc) >= 8'(threshold_reg)))
                        begin
                            s_cmd.shift_en  = 1'b1;
                            s_cmd.shift_pos = pos_reg;
                            mv_next         = '{key: req_reg.key, data: hit_data_reg,
                                                hits: hits_inc};
                            from_sev_next   = 1'b0;
                            room_move_next  = 1'b1;
                            state_next      = ST_MROOM;
                        end
                        else if (s_hit_reg)
                        begin
                            s_cmd.upd_en   = 1'b1;
                            s_cmd.upd_pos  = pos_reg;
                            s_cmd.upd_hits = hits_inc;
                        end
                        else if (m_hit_reg)
                        begin
                            m_cmd.upd_en   = 1'b1;
                            m_cmd.upd_pos  = pos_reg;
                            m_cmd.upd_hits = hits_inc;
                        end
                    end
                    tqf_pkg::OP_PUT:
                    begin
                        if (s_hit_reg || m_hit_reg)
                        begin
                            s_cmd.upd_en      = s_hit_reg;
                            m_cmd.upd_en      = m_hit_reg;
                            s_cmd.upd_data_en = 1'b1;
                            m_cmd.upd_data_en = 1'b1;
                            s_cmd.upd_pos     = pos_reg;
                            m_cmd.upd_pos     = pos_reg;
                            s_cmd.upd_data    = req_reg.write_value;
                            m_cmd.upd_data    = req_reg.write_value;
                            s_cmd.upd_hits    = hits_inc;
                            m_cmd.upd_hits    = hits_inc;
                        end
                        else
                        begin
                            if (g_hit_reg)
                            begin
                                g_cmd.shift_en  = 1'b1;
                                g_cmd.shift_pos = g_pos_reg;
                            end
                            ghost_mode_next = g_hit_reg;
                            state_next      = ST_SEV;
                        end
                    end
                    tqf_pkg::OP_REMOVE:
                    begin
                        s_cmd.shift_en  = s_hit_reg;
                        m_cmd.shift_en  = m_hit_reg;
                        s_cmd.shift_pos = pos_reg;
                        m_cmd.shift_pos = pos_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SEV:
            begin
                if (sev_go && (s_cnt_reg != '0))
                begin
                    // drop the oldest small entry: promote it or keep its key
                    s_cmd.shift_en  = 1'b1;
                    s_cmd.shift_pos = '0;
                    if (8'(small_ent[0].hits) >= 8'(threshold_reg))
                    begin
                        mv_next        = small_ent[0];
                        from_sev_next  = 1'b1;
                        room_move_next = 1'b1;
                        state_next     = ST_MROOM;
                    end
                    else
                    begin
                        gkey_next  = small_ent[0].key;
                        state_next = ST_GADD;
                    end
                end
                else if (ghost_mode_reg)
                begin
                    room_move_next = 1'b0;
                    state_next     = ST_MROOM;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_GADD:
            begin
                if (ghost_lim == '0)
                begin
                    state_next = ST_SEV;
                end
                else if (g_cnt_reg >= ghost_lim)
                begin
                    g_cmd.shift_en  = 1'b1;
                    g_cmd.shift_pos = '0;
                end
                else
                begin
                    g_cmd.push_en  = 1'b1;
                    g_cmd.push_pos = GIB'(g_cnt_reg);
                    g_cmd.push_key = gkey_reg;
                    state_next     = ST_SEV;
                end
            end
            ST_MROOM:
            begin
                if ((m_cnt_reg >= main_bound) && (m_cnt_reg != '0))
                begin
                    m_cmd.shift_en  = 1'b1;
                    m_cmd.shift_pos = '0;
                end
                else if (room_move_reg)
                begin
                    m_cmd.push_en  = 1'b1;
                    m_cmd.push_pos = SIB'(m_cnt_reg);
                    m_cmd.push_ent = mv_reg;
                    state_next     = from_sev_reg ? ST_SEV : ST_FIN;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (total < (CB + 1)'(CAP))
                begin
                    if (ghost_mode_reg)
                    begin
                        m_cmd.push_en  = 1'b1;
                        m_cmd.push_pos = SIB'(m_cnt_reg);
                        m_cmd.push_ent = '{key: req_reg.key, data: req_reg.write_value,
                                           hits: HB'(1)};
                    end
                    else
                    begin
                        s_cmd.push_en  = 1'b1;
                        s_cmd.push_pos = SIB'(s_cnt_reg);
                        s_cmd.push_ent = '{key: req_reg.key, data: req_reg.write_value,
                                           hits: HB'(1)};
                    end
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    fin_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            small_limit_reg <= 6'd6;
            ghost_limit_reg <= 7'd58;
            threshold_reg   <= 4'd2;
            s_cnt_reg       <= '0;
            m_cnt_reg       <= '0;
            g_cnt_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
            from_sev_reg    <= 1'b0;
            room_move_reg   <= 1'b0;
            ghost_mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            from_sev_reg   <= from_sev_next;
            room_move_reg  <= room_move_next;
            ghost_mode_reg <= ghost_mode_next;
            s_cnt_reg <= s_cnt_reg + CB'(s_cmd.push_en) - CB'(s_cmd.shift_en);
            m_cnt_reg <= m_cnt_reg + CB'(m_cmd.push_en) - CB'(m_cmd.shift_en);
            g_cnt_reg <= g_cnt_reg + GCB'(g_cmd.push_en) - GCB'(g_cmd.shift_en);
            if (cfg_we)
            begin
                case (cfg_index)
                    tqf_pkg::CFG_SMALL_LIMIT: small_limit_reg <= cfg_data[5:0];
                    tqf_pkg::CFG_GHOST_LIMIT: ghost_limit_reg <= cfg_data;
                    tqf_pkg::CFG_THRESHOLD:   threshold_reg   <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
            if (fin_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mv_reg   <= mv_next;
        gkey_reg <= gkey_next;
        if ((state_reg == ST_IDLE) && req_valid)
        begin
            req_reg <= req;
        end
        if (state_reg == ST_LOOK)
        begin
            s_hit_reg    <= s_hit;
            m_hit_reg    <= m_hit;
            g_hit_reg    <= g_hit;
            pos_reg      <= s_hit ? s_pos : m_pos;
            g_pos_reg    <= g_pos;
            hit_data_reg <= s_hit ? s_data : m_data;
            hit_cnt_reg  <= s_hit ? s_hits : m_hits;
        end
        if (fin_load)
        begin
            rsp_reg.hit        <= s_hit_reg || m_hit_reg;
            rsp_reg.read_value <= ((req_reg.opcode == tqf_pkg::OP_GET) &&
                                   (s_hit_reg || m_hit_reg)) ? hit_data_reg : -32'sd1;
            rsp_reg.occupancy  <= tqf_pkg::OCC_BITS'(total);
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
